### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types for the modular exponentiation controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_RED   = 7'b0000100,
    S_BIT   = 7'b0001000,
    S_MULX  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_SQR   = 7'b1000000
  } state_e;

  // multiplicand select of the modular multiplier
  typedef enum logic [1:0] {
    OPA_ONE = 2'd0,
    OPA_X   = 2'd1,
    OPA_P   = 2'd2
  } opa_sel_e;

  // multiplier select (scanned msb first)
  typedef enum logic {
    MLT_B = 1'b0,
    MLT_P = 1'b1
  } mlt_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    opa_sel_e opa_sel;
    mlt_sel_e mlt_sel;
    logic     mul_step;
    logic     p_take_acc;
    logic     x_take_p;
    logic     x_take_acc;
    logic     n_shift;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic n_zero;
    logic n_bit0;
    logic n_rest_zero;
    logic x_first;
    logic mul_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// operand registers, shift-and-add modular multiplier and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mexp_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire mexp_pkg::cmd_t                 cmd_i,
  output mexp_pkg::status_t                   status_o,
  input  wire  [mexp_pkg::FieldW-1:0]         base_i,
  input  wire  [mexp_pkg::FieldW-1:0]         exponent_i,
  input  wire  [mexp_pkg::FieldW-1:0]         modulus_i,
  output logic [mexp_pkg::FieldW-1:0]         result_o,
  output logic                                bad_modulus_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] b_q, b_d, n_q, n_d, m_q, m_d;
  logic [WIDTH-1:0] x_q, x_d, p_q, p_d;
  logic [WIDTH-1:0] acc_q, acc_d, opa_q, opa_d, mlt_q, mlt_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             x_first_q, x_first_d;
  logic [mexp_pkg::FieldW-1:0] res_q, res_d;
  logic             bad_q, bad_d;
  logic             out_valid_q, out_valid_d;

  // one multiplier bit per cycle: acc = 2*acc (+ opa) mod m
  logic [WIDTH:0]   dbl, sum;
  logic [WIDTH-1:0] acc2, acc3, addend;

  always_comb begin
    dbl    = {1'b0, acc_q} + {1'b0, acc_q};
    acc2   = (dbl >= {1'b0, m_q}) ? WIDTH'(dbl - {1'b0, m_q}) : dbl[WIDTH-1:0];
    addend = mlt_q[WIDTH-1] ? opa_q : '0;
    sum    = {1'b0, acc2} + {1'b0, addend};
    acc3   = (sum >= {1'b0, m_q}) ? WIDTH'(sum - {1'b0, m_q}) : sum[WIDTH-1:0];
  end

  always_comb begin
    b_d         = b_q;
    n_d         = n_q;
    m_d         = m_q;
    x_d         = x_q;
    p_d         = p_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    mlt_d       = mlt_q;
    cnt_d       = cnt_q;
    x_first_d   = x_first_q;
    res_d       = res_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      b_d       = WIDTH'(base_i);
      n_d       = WIDTH'(exponent_i);
      m_d       = WIDTH'(modulus_i);
      x_d       = WIDTH'(1);
      x_first_d = 1'b1;
    end

    if (cmd_i.mul_start) begin
      acc_d = '0;
      cnt_d = '0;
      case (cmd_i.opa_sel)
        mexp_pkg::OPA_ONE: opa_d = WIDTH'(1);
        mexp_pkg::OPA_X:   opa_d = x_q;
        mexp_pkg::OPA_P:   opa_d = p_q;
        default:           opa_d = p_q;
      endcase
      mlt_d = (cmd_i.mlt_sel == mexp_pkg::MLT_B) ? b_q : p_q;
    end

    if (cmd_i.mul_step) begin
      acc_d = acc3;
      mlt_d = {mlt_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
    end

    if (cmd_i.p_take_acc) begin
      p_d = acc3;
    end
    if (cmd_i.x_take_acc) begin
      x_d       = acc3;
      x_first_d = 1'b0;
    end
    if (cmd_i.x_take_p) begin
      x_d       = p_q;
      x_first_d = 1'b0;
    end
    if (cmd_i.n_shift) begin
      n_d = {1'b0, n_q[WIDTH-1:1]};
    end

    if (cmd_i.out_load) begin
      res_d       = (m_q == '0) ? '0 : mexp_pkg::FieldW'(x_q);
      bad_d       = (m_q == '0);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      x_first_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      x_first_q   <= x_first_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    n_q   <= n_d;
    m_q   <= m_d;
    x_q   <= x_d;
    p_q   <= p_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    mlt_q <= mlt_d;
    res_q <= res_d;
    bad_q <= bad_d;
  end

  always_comb begin
    status_o.m_zero      = (m_q == '0);
    status_o.n_zero      = (n_q == '0);
    status_o.n_bit0      = n_q[0];
    status_o.n_rest_zero = (n_q[WIDTH-1:1] == '0);
    status_o.x_first     = x_first_q;
    status_o.mul_last    = (cnt_q == CntW'(WIDTH - 1));
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign result_o      = res_q;
  assign bad_modulus_o = bad_q;
  assign out_valid_o   = out_valid_q;

  `ASSERT_RST(a_acc_reduced, clk_i, rst_ni, cmd_i.mul_step |-> (acc_q < m_q) && (opa_q <= m_q), "multiplier accumulator not reduced")
  `ASSERT_RST(a_x_take_p_once, clk_i, rst_ni, cmd_i.x_take_p |-> x_first_q, "power copied into x after first multiply")

endmodule

`default_nettype wire

### sv/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for reduction, multiply and square passes of the exponent scan
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mexp_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  output mexp_pkg::cmd_t          cmd_o,
  input  wire mexp_pkg::status_t  status_i
);

  mexp_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mexp_pkg::S_START;
        end
      end
      mexp_pkg::S_START: begin
        if (status_i.m_zero) begin
          done_d  = 1'b1;
          state_d = mexp_pkg::S_NEXT;
        end else begin
          // power = base mod m, as base times one
          cmd_o.mul_start = 1'b1;
          cmd_o.opa_sel   = mexp_pkg::OPA_ONE;
          cmd_o.mlt_sel   = mexp_pkg::MLT_B;
          state_d         = mexp_pkg::S_RED;
        end
      end
      mexp_pkg::S_RED: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.p_take_acc = 1'b1;
          state_d          = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_BIT: begin
        if (status_i.n_zero) begin
          done_d  = 1'b1;
          state_d = mexp_pkg::S_NEXT;
        end else if (status_i.n_bit0 && status_i.x_first) begin
          // first multiply of x = 1 by power is just power
          cmd_o.x_take_p = 1'b1;
          state_d        = mexp_pkg::S_NEXT;
        end else if (status_i.n_bit0) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.opa_sel   = mexp_pkg::OPA_X;
          cmd_o.mlt_sel   = mexp_pkg::MLT_P;
          state_d         = mexp_pkg::S_MULX;
        end else begin
          state_d = mexp_pkg::S_NEXT;
        end
      end
      mexp_pkg::S_MULX: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.x_take_acc = 1'b1;
          state_d          = mexp_pkg::S_NEXT;
        end
      end
      mexp_pkg::S_NEXT: begin
        // done_q marks a finished run: zero modulus, zero exponent or a wait for the output register
        if (done_q || status_i.n_rest_zero) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = mexp_pkg::S_IDLE;
          end else begin
            done_d = 1'b1;
          end
        end else begin
          cmd_o.n_shift   = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.opa_sel   = mexp_pkg::OPA_P;
          cmd_o.mlt_sel   = mexp_pkg::MLT_P;
          state_d         = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_SQR: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          cmd_o.p_take_acc = 1'b1;
          state_d          = mexp_pkg::S_BIT;
        end
      end
      default: begin
        state_d = mexp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  `ASSERT_RST(a_mulx_to_next, clk_i, rst_ni, (state_q == mexp_pkg::S_MULX) && status_i.mul_last |=> (state_q == mexp_pkg::S_NEXT), "multiply pass did not end")
  `ASSERT_RST(a_done_holds, clk_i, rst_ni, done_q |-> (state_q == mexp_pkg::S_NEXT), "finish flag outside wait state")

endmodule

`default_nettype wire

### sv/modular_exponentiation_top.sv
// a result follows one reduction pass of base mod m; each exponent bit above the lowest, up to
// the highest set bit, adds a square pass, and each set bit after the first set bit adds a multiply pass;
// a zero modulus skips all passes and answers with a zero result and the error flag
// one transaction in flight; the next is accepted the cycle after the result is loaded
// rst_ni is asynchronous, active low; clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// right-to-left binary modular exponentiation with stream ports
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top #(
  parameter int unsigned WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [95:0] s_axis_tdata_i,   // base [31:0], exponent [63:32], modulus [95:64]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // result [31:0]
  output logic        m_axis_tuser_o    // bad_modulus [0]
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .base_i        (s_axis_tdata_i[31:0]),
    .exponent_i    (s_axis_tdata_i[63:32]),
    .modulus_i     (s_axis_tdata_i[95:64]),
    .result_o      (m_axis_tdata_o),
    .bad_modulus_o (m_axis_tuser_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i)
  );

endmodule

`default_nettype wire
